// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the median filter.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while rst is high
`define MF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter: implication check failed");

// next-cycle implication, masked while rst is high
`define MF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter: next-cycle check failed");

// next-cycle implication that also runs through reset
`define MF_ASSERT_NXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("median filter: reset check failed");

`endif

// File: rtl/mf_pkg.sv
// Package of the 3x3 median filter: sizes, register codes and the types
// passed between the csr, front and back modules. No dependencies.
`timescale 1ns / 1ps

package mf_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W  = 8;
   localparam int POS_W  = 12;
   localparam int DIM_W  = 13;
   localparam int COL_AW = $clog2(MAX_WIDTH);

   localparam int DIM_MIN      = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 8;

   localparam int WIN_CELLS = 9;
   localparam int WIN_CENTER = 4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN_CELLS-1:0] window_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             restart;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             interior;
      logic             last;
   } side_type;

   typedef struct packed {
      pix_type           pix;
      logic [COL_AW-1:0] addr;
      logic              emit;
      side_type          side;
   } desc_type;

endpackage

// File: rtl/mf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mf_csr.sv
// Configuration registers of the median filter behind an APB-style port.
// Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                           pready,
   output mf_pkg::cfg_type                cfg
);
   import mf_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_hit;
   csr_reg_type      reg_sel;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(DIM_MIN)) begin
         r = DIM_W'(DIM_MIN);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign pready  = 1'b1;
   assign wr_hit  = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      prdata    = '0;
      case (reg_sel)
         REG_IMAGE_WIDTH: begin
            prdata = CSR_DATA_W'(width_ff);
            if (wr_hit) begin
               width_in = clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
            end
         end
         REG_IMAGE_HEIGHT: begin
            prdata = CSR_DATA_W'(height_ff);
            if (wr_hit) begin
               height_in = clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_RESET);
         height_ff <= DIM_W'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // any write restarts the image, counters clear on the same edge
   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.restart = wr_hit;

endmodule

// File: rtl/mf_front.sv
// Front end of the median filter: accepts items, tracks the input and output
// positions, and queues one descriptor per pixel that moves the window.
// Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_front (
   input  logic              clock,
   input  logic              reset,
   input  mf_pkg::cfg_type   cfg,
   input  logic              push,
   output logic              full,
   input  logic              req_mode,
   input  mf_pkg::pix_type   req_pixel_in,
   input  logic              q_pop,
   output logic              q_valid,
   output mf_pkg::desc_type  q_head
);
   import mf_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DIM_W-1:0]  in_row_ff, in_row_in;
   logic [COL_AW-1:0] in_col_ff, in_col_in;
   logic [POS_W-1:0]  emit_row_ff, emit_row_in;
   logic [POS_W-1:0]  emit_col_ff, emit_col_in;

   desc_type          q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;

   logic             accept, complete, drop, take, emit, interior, last;
   logic             col_wrap, ecol_wrap;
   logic [DIM_W-1:0] er_x, ec_x;
   desc_type         desc;

   assign accept   = push && !full;
   assign complete = in_row_ff >= cfg.height;
   // a flush before the image is complete does nothing
   assign drop     = req_mode && !complete;
   assign take     = accept && !drop;

   assign emit = (in_row_ff >= DIM_W'(2)) ||
                 ((in_row_ff == DIM_W'(1)) && (in_col_ff != '0));

   assign er_x     = DIM_W'(emit_row_ff);
   assign ec_x     = DIM_W'(emit_col_ff);
   assign interior = (emit_row_ff != '0) && ((er_x + DIM_W'(2)) <= cfg.height) &&
                     (emit_col_ff != '0) && ((ec_x + DIM_W'(2)) <= cfg.width);
   assign last     = ((er_x + DIM_W'(1)) == cfg.height) &&
                     ((ec_x + DIM_W'(1)) == cfg.width);

   assign col_wrap  = (DIM_W'(in_col_ff) + DIM_W'(1)) >= cfg.width;
   assign ecol_wrap = (ec_x + DIM_W'(1)) >= cfg.width;

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      if (cfg.restart) begin
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (take) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_AW'(1);
         end
         if (emit) begin
            if (last) begin
               in_row_in   = '0;
               in_col_in   = '0;
               emit_row_in = '0;
               emit_col_in = '0;
            end else if (ecol_wrap) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + POS_W'(1);
            end else begin
               emit_col_in = emit_col_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
      end
   end

   // past the last row, zeros are shifted in as virtual pixels
   assign desc.pix           = complete ? '0 : req_pixel_in;
   assign desc.addr          = in_col_ff;
   assign desc.emit          = emit;
   assign desc.side.row      = emit_row_ff;
   assign desc.side.col      = emit_col_ff;
   assign desc.side.interior = interior;
   assign desc.side.last     = last;

   // descriptor queue
   assign full    = q_count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_valid = q_count_ff != '0;
   assign q_head  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      if (take) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (take && !q_pop) begin
         q_count_in = q_count_ff + QCNT_W'(1);
      end else if (q_pop && !take) begin
         q_count_in = q_count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_mem_ff[wr_ptr_ff] <= desc;
      end
   end

endmodule

// File: rtl/mf_median.sv
// Two-stage median-of-nine network: column sorts, then max/med/min across
// columns, final med3 on the output. Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_median (
   input  logic               clock,
   input  mf_pkg::window_type win,
   output mf_pkg::pix_type    median
);
   import mf_pkg::*;

   pix_type lo_ff [3], mid_ff [3], hi_ff [3];
   pix_type lo_in [3], mid_in [3], hi_in [3];
   pix_type a_ff, b_ff, c_ff, a_in, b_in, c_in;

   function automatic pix_type min2(input pix_type x, input pix_type y);
      return (x < y) ? x : y;
   endfunction

   function automatic pix_type max2(input pix_type x, input pix_type y);
      return (x > y) ? x : y;
   endfunction

   function automatic pix_type med3(input pix_type x, input pix_type y, input pix_type z);
      return max2(min2(x, y), min2(max2(x, y), z));
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k]  = min2(min2(win[k], win[k+3]), win[k+6]);
         mid_in[k] = med3(win[k], win[k+3], win[k+6]);
         hi_in[k]  = max2(max2(win[k], win[k+3]), win[k+6]);
      end
   end

   // median of nine = med3(max of lows, med of mids, min of highs)
   assign a_in = max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
   assign b_in = med3(mid_ff[0], mid_ff[1], mid_ff[2]);
   assign c_in = min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
   end

   assign median = med3(a_ff, b_ff, c_ff);

endmodule

// File: rtl/mf_back.sv
// Back end of the median filter: line store RAM, 3x3 window, median network
// and the result queue with its reservation count. Depends on mf_pkg,
// mf_ram and mf_median.
`timescale 1ns / 1ps

module mf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  mf_pkg::desc_type        q_head,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output mf_pkg::pix_type         rsp_pixel_out,
   output logic [mf_pkg::POS_W-1:0] rsp_out_row,
   output logic [mf_pkg::POS_W-1:0] rsp_out_column,
   output logic                    rsp_last_pixel
);
   import mf_pkg::*;

   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      pix_type          pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } result_type;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   desc_type            d1_ff;
   side_type            side2_ff, side3_ff, side4_ff;
   pix_type             center3_ff, center4_ff;
   window_type          win_ff, win_in;
   logic [2*PIX_W-1:0]  line_rd;
   pix_type             up, mid, med;

   result_type          o_mem_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]   o_wr_ff, o_wr_in, o_rd_ff, o_rd_in;
   logic [OCNT_W-1:0]   o_count_ff, o_count_in;
   logic [OCNT_W-1:0]   credit_ff, credit_in;
   logic                rsp_take;
   result_type          result;

   // a window-moving item with a result needs a free slot reserved downstream
   assign q_pop = q_valid && (!q_head.emit || (credit_ff < OCNT_W'(OUT_DEPTH)));

   // upper row in the high byte, middle row in the low byte
   mf_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (v1_ff),
      .wr_addr (d1_ff.addr),
      .wr_data ({mid, d1_ff.pix}),
      .rd_addr (q_head.addr),
      .rd_data (line_rd)
   );

   assign up  = line_rd[2*PIX_W-1:PIX_W];
   assign mid = line_rd[PIX_W-1:0];

   always_comb begin
      win_in = win_ff;
      if (v1_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = up;
         win_in[5] = mid;
         win_in[8] = d1_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff && d1_ff.emit;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff      <= q_head;
      win_ff     <= win_in;
      side2_ff   <= d1_ff.side;
      side3_ff   <= side2_ff;
      side4_ff   <= side3_ff;
      center3_ff <= win_ff[WIN_CENTER];
      center4_ff <= center3_ff;
   end

   mf_median u_med (
      .clock  (clock),
      .win    (win_ff),
      .median (med)
   );

   assign result.pixel = side4_ff.interior ? med : center4_ff;
   assign result.row   = side4_ff.row;
   assign result.col   = side4_ff.col;
   assign result.last  = side4_ff.last;

   // result queue
   assign empty    = o_count_ff == '0;
   assign rsp_take = pop && !empty;

   assign rsp_pixel_out  = o_mem_ff[o_rd_ff].pixel;
   assign rsp_out_row    = o_mem_ff[o_rd_ff].row;
   assign rsp_out_column = o_mem_ff[o_rd_ff].col;
   assign rsp_last_pixel = o_mem_ff[o_rd_ff].last;

   always_comb begin
      o_wr_in    = o_wr_ff;
      o_rd_in    = o_rd_ff;
      o_count_in = o_count_ff;
      credit_in  = credit_ff;
      if (v4_ff) begin
         o_wr_in = (o_wr_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_wr_ff + OPTR_W'(1);
      end
      if (rsp_take) begin
         o_rd_in = (o_rd_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_rd_ff + OPTR_W'(1);
      end
      if (v4_ff && !rsp_take) begin
         o_count_in = o_count_ff + OCNT_W'(1);
      end else if (rsp_take && !v4_ff) begin
         o_count_in = o_count_ff - OCNT_W'(1);
      end
      if ((q_pop && q_head.emit) && !rsp_take) begin
         credit_in = credit_ff + OCNT_W'(1);
      end else if (rsp_take && !(q_pop && q_head.emit)) begin
         credit_in = credit_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff    <= '0;
         o_rd_ff    <= '0;
         o_count_ff <= '0;
         credit_ff  <= '0;
      end else begin
         o_wr_ff    <= o_wr_in;
         o_rd_ff    <= o_rd_in;
         o_count_ff <= o_count_in;
         credit_ff  <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v4_ff) begin
         o_mem_ff[o_wr_ff] <= result;
      end
   end

endmodule

// File: rtl/median_filter_3x3.sv
// Channel     | direction | handshake              | payload
// req         | in        | push / full            | req_mode, req_pixel_in
// rsp         | out       | empty / pop            | rsp_pixel_out, rsp_out_row, rsp_out_column,
//             |           |                        | rsp_last_pixel
// csr         | in/out    | psel, penable, pready  | paddr, pwdata, prdata
//
// One item per clock unless the back end waits for a result slot; the line store RAM is
// read and written once per item; items then pass the window and median registers.
// Results lag the input by one row plus one item; flush items drain the tail.
// Reset clears counters and queues; line stores need no clearing, every entry is
// rewritten in the current image before it can reach a result.
// full rises with 4 queued items; the back end waits when 8 result slots are reserved.
//
// Top level of the 3x3 median filter. Depends on mf_pkg, mf_csr, mf_front, mf_back.
`timescale 1ns / 1ps

module median_filter_3x3 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_mode,
   input  logic [mf_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                           empty,
   input  logic                           pop,
   output logic [mf_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic [mf_pkg::POS_W-1:0]       rsp_out_row,
   output logic [mf_pkg::POS_W-1:0]       rsp_out_column,
   output logic                           rsp_last_pixel,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                           pready
);
   import mf_pkg::*;

   cfg_type  cfg;
   desc_type q_head;
   logic     q_valid, q_pop;

   mf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .push         (push),
      .full         (full),
      .req_mode     (req_mode),
      .req_pixel_in (req_pixel_in),
      .q_pop        (q_pop),
      .q_valid      (q_valid),
      .q_head       (q_head)
   );

   mf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

// File: rtl/mf_checker.sv
// Port-level checks for the median filter, bound to the top level.
// Depends on assert_macros.svh and the port names of median_filter_3x3.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mf_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_pixel_out,
   input logic [11:0] rsp_out_row,
   input logic [11:0] rsp_out_column,
   input logic        rsp_last_pixel
);

   logic rsp_take;
   logic seen_last_ff, seen_last_in;

   assign rsp_take = pop && !empty;

   // set after the closing item of an image; the next one starts at the origin
   always_comb begin
      seen_last_in = seen_last_ff;
      if (rsp_take) begin
         seen_last_in = rsp_last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_last_ff <= 1'b0;
      end else begin
         seen_last_ff <= seen_last_in;
      end
   end

   `MF_ASSERT_NXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_pixel_out) && $stable(rsp_out_row) && $stable(rsp_out_column) && $stable(rsp_last_pixel))
   `MF_ASSERT_NXT_NR(a_reset_idle, clock, reset, empty && !full)
   `MF_ASSERT_IMP(a_last_pos, clock, reset, rsp_take && rsp_last_pixel, (rsp_out_row >= 12'd2) && (rsp_out_column >= 12'd2))
   `MF_ASSERT_IMP(a_restart_origin, clock, reset, rsp_take && seen_last_ff, (rsp_out_row == 12'd0) && (rsp_out_column == 12'd0))

endmodule

bind median_filter_3x3 mf_checker u_checker (.*);
